FILE: src/ssi_pkg.sv
// Shared constants and helpers for the sphere pair intersection pipeline.
package ssi_pkg;
  localparam int FRAC_BITS = 16;
  localparam int SQ_STAGES = 34;
  localparam int DIV_BITS = 15;
  localparam logic [14:0] NORM_ONE = 15'd16384;
  localparam logic [30:0] RADIUS_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [32:0] mag_x;
    logic [32:0] mag_y;
    logic [32:0] mag_z;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic [30:0] r1;
    logic [30:0] r2;
    logic [31:0] comb;
  } ssi_geom_t;

  function automatic logic [30:0] sat_radius(input logic [46:0] p);
    logic [38:0] s;
    s = p[46:8];
    return (s > {8'd0, RADIUS_MAX}) ? RADIUS_MAX : s[30:0];
  endfunction
endpackage

FILE: src/sphere_sphere_intersect.sv
// Sphere pair intersection: stages A, B, C, the square root, the normal division, E and the output stage F.
// Throughput one word per cycle; busy is held low, the pipeline never stalls.
// Square root is 34 restoring stages, normal division 15 stages per lane.
// rst clears every stage valid bit; payload registers are not reset.
// The receiver cannot stall: results appear for one cycle with done high.
module sphere_sphere_intersect import ssi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] first_x,
  input  logic signed [31:0] first_y,
  input  logic signed [31:0] first_z,
  input  logic        [30:0] first_radius,
  input  logic        [15:0] first_scale,
  input  logic signed [31:0] second_x,
  input  logic signed [31:0] second_y,
  input  logic signed [31:0] second_z,
  input  logic        [30:0] second_radius,
  input  logic        [15:0] second_scale,
  output logic               done,
  output logic               hit,
  output logic        [31:0] depth,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic signed [31:0] contact_first_x,
  output logic signed [31:0] contact_first_y,
  output logic signed [31:0] contact_first_z,
  output logic signed [31:0] contact_second_x,
  output logic signed [31:0] contact_second_y,
  output logic signed [31:0] contact_second_z
);
  assign busy = 1'b0;

  // stage A: differences, scaled radii
  logic      va;
  ssi_geom_t ga;
  logic signed [32:0] dx, dy, dz;
  always_comb begin
    dx = {first_x[31], first_x} - {second_x[31], second_x};
    dy = {first_y[31], first_y} - {second_y[31], second_y};
    dz = {first_z[31], first_z} - {second_z[31], second_z};
  end
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= start;
    ga.neg_x <= dx[32];
    ga.neg_y <= dy[32];
    ga.neg_z <= dz[32];
    ga.mag_x <= dx[32] ? -dx : dx;
    ga.mag_y <= dy[32] ? -dy : dy;
    ga.mag_z <= dz[32] ? -dz : dz;
    ga.r1 <= first_radius;
    ga.r2 <= second_radius;
    ga.comb <= {1'b0, sat_radius({16'd0, first_radius} * {31'd0, first_scale})}
             + {1'b0, sat_radius({16'd0, second_radius} * {31'd0, second_scale})};
  end

  // stage B: squares
  logic      vb;
  ssi_geom_t gb;
  logic [65:0] sqx, sqy, sqz;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else vb <= va;
    gb <= ga;
    sqx <= {33'd0, ga.mag_x} * {33'd0, ga.mag_x};
    sqy <= {33'd0, ga.mag_y} * {33'd0, ga.mag_y};
    sqz <= {33'd0, ga.mag_z} * {33'd0, ga.mag_z};
  end

  // stage C: sum of squares
  logic      vc;
  ssi_geom_t gc;
  logic [67:0] ssum;
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else vc <= vb;
    gc <= gb;
    ssum <= {2'b0, sqx} + {2'b0, sqy} + {2'b0, sqz};
  end

  // square root, one result bit per stage (restoring, remainder form)
  logic      sv   [SQ_STAGES+1];
  ssi_geom_t sg   [SQ_STAGES+1];
  logic [67:0] srem [SQ_STAGES+1];
  logic [67:0] sx   [SQ_STAGES+1];
  logic [33:0] sroot[SQ_STAGES+1];
  assign sv[0] = vc;
  assign sg[0] = gc;
  assign srem[0] = 68'd0;
  assign sx[0] = ssum;
  assign sroot[0] = 34'd0;
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic [69:0] rem_sh, trial;
    always_comb begin
      rem_sh = {srem[k], sx[k][67:66]};
      trial = rem_sh - {34'd0, sroot[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else sv[k+1] <= sv[k];
      sg[k+1] <= sg[k];
      sx[k+1] <= {sx[k][65:0], 2'b00};
      if (!trial[69]) begin
        srem[k+1] <= trial[67:0];
        sroot[k+1] <= {sroot[k][32:0], 1'b1};
      end else begin
        srem[k+1] <= rem_sh[67:0];
        sroot[k+1] <= {sroot[k][32:0], 1'b0};
      end
    end
  end

  logic      vd;
  ssi_geom_t gd;
  logic [33:0] distance;
  logic        hd;
  assign vd = sv[SQ_STAGES];
  assign gd = sg[SQ_STAGES];
  assign distance = sroot[SQ_STAGES];
  assign hd = distance < {2'b0, gd.comb};

  // normal division: q = (m*16384 + distance/2) / distance, 15 quotient bits, q <= 16384 capped
  // numerator over distance: m <= distance so q < 2^15
  logic        qv   [DIV_BITS+1];
  ssi_geom_t   qg   [DIV_BITS+1];
  logic        qh   [DIV_BITS+1];
  logic [33:0] qd   [DIV_BITS+1];
  logic [48:0] qn   [DIV_BITS+1][3];
  logic [34:0] qr   [DIV_BITS+1][3];
  logic [14:0] qq   [DIV_BITS+1][3];
  assign qv[0] = vd;
  assign qg[0] = gd;
  assign qh[0] = hd;
  assign qd[0] = distance;
  assign qn[0][0] = {2'b0, gd.mag_x[32:0], 14'd0} + {16'd0, distance[33:1]};
  assign qn[0][1] = {2'b0, gd.mag_y[32:0], 14'd0} + {16'd0, distance[33:1]};
  assign qn[0][2] = {2'b0, gd.mag_z[32:0], 14'd0} + {16'd0, distance[33:1]};
  for (genvar c = 0; c < 3; c++) begin : g_q0
    // top 34 bits seed remainder; quotient fits in 15 bits
    assign qr[0][c] = {1'b0, qn[0][c][48:15]};
    assign qq[0][c] = 15'd0;
  end
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) qv[k+1] <= 1'b0;
      else qv[k+1] <= qv[k];
      qg[k+1] <= qg[k];
      qh[k+1] <= qh[k];
      qd[k+1] <= qd[k];
    end
    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [35:0] sh, tr;
      always_comb begin
        sh = {qr[k][c], qn[k][c][14]};
        tr = sh - {2'b0, qd[k]};
      end
      always_ff @(posedge clk) begin
        qn[k+1][c] <= {qn[k][c][47:0], 1'b0};
        if (!tr[35]) begin
          qr[k+1][c] <= tr[34:0];
          qq[k+1][c] <= {qq[k][c][13:0], 1'b1};
        end else begin
          qr[k+1][c] <= sh[34:0];
          qq[k+1][c] <= {qq[k][c][13:0], 1'b0};
        end
      end
    end
  end

  // stage E: clamp, sign, depth
  logic        ve, he;
  logic [31:0] dep_e;
  logic [14:0] nm_e [3];
  logic        ng_e [3];
  logic [30:0] r1e, r2e;
  always_ff @(posedge clk) begin
    if (rst) ve <= 1'b0;
    else ve <= qv[DIV_BITS];
    he <= qh[DIV_BITS];
    dep_e <= qg[DIV_BITS].comb - qd[DIV_BITS][31:0];
    r1e <= qg[DIV_BITS].r1;
    r2e <= qg[DIV_BITS].r2;
    ng_e[0] <= qg[DIV_BITS].neg_x;
    ng_e[1] <= qg[DIV_BITS].neg_y;
    ng_e[2] <= qg[DIV_BITS].neg_z;
    for (int c = 0; c < 3; c++) begin
      if (qd[DIV_BITS] == 34'd0) nm_e[c] <= 15'd0;
      else nm_e[c] <= (qq[DIV_BITS][c] > NORM_ONE) ? NORM_ONE : qq[DIV_BITS][c];
    end
  end

  // stage F: contacts, output register
  logic [45:0] p1 [3], p2 [3];
  logic [31:0] c1 [3], c2 [3];
  logic signed [15:0] nsg [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      p1[c] = {31'd0, nm_e[c]} * {15'd0, r1e} + 46'd8192;
      p2[c] = {31'd0, nm_e[c]} * {15'd0, r2e} + 46'd8192;
      c1[c] = ng_e[c] ? -p1[c][45:14] : p1[c][45:14];
      c2[c] = ng_e[c] ? p2[c][45:14] : -p2[c][45:14];
      nsg[c] = ng_e[c] ? -{1'b0, nm_e[c]} : {1'b0, nm_e[c]};
    end
  end
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= ve;
    hit <= he;
    depth <= he ? dep_e : 32'd0;
    normal_x <= he ? nsg[0] : 16'sd0;
    normal_y <= he ? nsg[1] : 16'sd0;
    normal_z <= he ? nsg[2] : 16'sd0;
    contact_first_x <= he ? c1[0] : 32'sd0;
    contact_first_y <= he ? c1[1] : 32'sd0;
    contact_first_z <= he ? c1[2] : 32'sd0;
    contact_second_x <= he ? c2[0] : 32'sd0;
    contact_second_y <= he ? c2[1] : 32'sd0;
    contact_second_z <= he ? c2[2] : 32'sd0;
  end
endmodule

FILE: src/ssi_checker.sv
// Port-level checker for the sphere pair intersection block, with its bind.
module ssi_checker import ssi_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               done,
  input logic               hit,
  input logic        [31:0] depth,
  input logic signed [15:0] normal_x,
  input logic signed [31:0] contact_first_x
);
  a_never_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (depth == 32'd0 && normal_x == 16'sd0 && contact_first_x == 32'sd0))
    else $error("miss result not zero");
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (normal_x <= 16'sd16384 && normal_x >= -16'sd16384))
    else $error("normal out of range");
endmodule

bind sphere_sphere_intersect ssi_checker u_ssi_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .hit(hit), .depth(depth),
  .normal_x(normal_x), .contact_first_x(contact_first_x)
);
